FILE: design/sfr_pkg.sv
// Shared types and constants for the serial frame receiver.
package sfr_pkg;

  localparam logic [7:0] HDR_FIRST  = 8'h48;
  localparam logic [7:0] HDR_SECOND = 8'h44;
  localparam logic [7:0] TRL_FIRST  = 8'h54;
  localparam logic [7:0] TRL_SECOND = 8'h4C;

  localparam int BODY_LEN = 3;

  typedef enum logic [5:0] {
    PH_HDR_A = 6'b000001,
    PH_HDR_B = 6'b000010,
    PH_BODY  = 6'b000100,
    PH_SUM   = 6'b001000,
    PH_TRL_A = 6'b010000,
    PH_TRL_B = 6'b100000
  } phase_t;

  typedef struct packed {
    logic       checksum_bad;
    logic [7:0] second_param;
    logic [7:0] first_param;
    logic [7:0] event_code;
  } frame_result_t;

  // Header byte while a frame is dropped: jump straight to the second header.
  function automatic phase_t resync_phase(input logic [7:0] b);
    resync_phase = (b == HDR_FIRST) ? PH_HDR_B : PH_HDR_A;
  endfunction

endpackage

FILE: design/sfr_parser.sv
// Frame phase tracking, body capture and checksum check for one byte per cycle while step is high.
module sfr_parser (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  logic [7:0]             rx_byte,
  output logic                   emit,
  output sfr_pkg::frame_result_t result
);

  sfr_pkg::phase_t phase, phase_next;
  logic [1:0]      body_count, body_count_next;
  logic [7:0]      body_store [sfr_pkg::BODY_LEN];
  logic            sum_error_flag, sum_error_flag_next;
  logic [7:0]      body_sum;

  assign body_sum = body_store[0] + body_store[1] + body_store[2];

  always_comb begin
    phase_next          = phase;
    body_count_next     = body_count;
    sum_error_flag_next = sum_error_flag;
    emit                = 1'b0;
    case (phase)
      sfr_pkg::PH_HDR_A: begin
        if (rx_byte == sfr_pkg::HDR_FIRST) phase_next = sfr_pkg::PH_HDR_B;
      end
      sfr_pkg::PH_HDR_B: begin
        if (rx_byte == sfr_pkg::HDR_SECOND) phase_next = sfr_pkg::PH_BODY;
        else phase_next = sfr_pkg::resync_phase(rx_byte);
      end
      sfr_pkg::PH_BODY: begin
        if (body_count >= 2'd2) begin
          body_count_next = 2'd0;
          phase_next      = sfr_pkg::PH_SUM;
        end else begin
          body_count_next = body_count + 2'd1;
        end
      end
      sfr_pkg::PH_SUM: begin
        sum_error_flag_next = (rx_byte != body_sum);
        phase_next          = sfr_pkg::PH_TRL_A;
      end
      sfr_pkg::PH_TRL_A: begin
        if (rx_byte == sfr_pkg::TRL_FIRST) phase_next = sfr_pkg::PH_TRL_B;
        else phase_next = sfr_pkg::resync_phase(rx_byte);
      end
      sfr_pkg::PH_TRL_B: begin
        if (rx_byte == sfr_pkg::TRL_SECOND) begin
          emit       = 1'b1;
          phase_next = sfr_pkg::PH_HDR_A;
        end else begin
          phase_next = sfr_pkg::resync_phase(rx_byte);
        end
      end
      default: begin
        phase_next = sfr_pkg::PH_HDR_A;
      end
    endcase
  end

  assign result.event_code   = body_store[0];
  assign result.first_param  = body_store[1];
  assign result.second_param = body_store[2];
  assign result.checksum_bad = sum_error_flag;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= sfr_pkg::PH_HDR_A;
      body_count     <= 2'd0;
      sum_error_flag <= 1'b0;
    end else if (step) begin
      phase          <= phase_next;
      body_count     <= body_count_next;
      sum_error_flag <= sum_error_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step && phase == sfr_pkg::PH_BODY) begin
      case (body_count)
        2'd0:    body_store[0] <= rx_byte;
        2'd1:    body_store[1] <= rx_byte;
        default: body_store[2] <= rx_byte;
      endcase
    end
  end

endmodule

FILE: design/sfr_out_reg.sv
// Result register holding one finished frame until the sink takes it.
module sfr_out_reg (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  sfr_pkg::frame_result_t load_result,
  input  logic                   take,
  output logic                   free,
  output logic                   valid,
  output sfr_pkg::frame_result_t result
);

  assign free = !valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (take) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) result <= load_result;
  end

endmodule

FILE: design/serial_frame_receiver_unit.sv
// Top level of the serial frame receiver: input register, parser and result register.
// One received byte is taken per word on the s side, one per cycle unless a stall holds it; a finished
// frame passes through the input register and the parser into the result register, which drives the m side.
// The rate is set by the parser, which updates the frame phase for one byte per
// cycle. Bytes that finish no frame keep flowing while a result waits;
// only a byte that completes a frame waits for the result register to empty.
module serial_frame_receiver_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [7:0] event_code, [15:8] first_param, [23:16] second_param
  output logic        m_tuser    // [0] checksum_bad
);

  logic                   in_valid;
  logic [7:0]             in_byte;
  logic                   emit;
  logic                   out_free;
  logic                   advance;
  sfr_pkg::frame_result_t parse_result;
  sfr_pkg::frame_result_t out_result;

  assign advance  = in_valid && (!emit || out_free);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) in_byte <= s_tdata;
  end

  sfr_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .rx_byte (in_byte),
    .emit    (emit),
    .result  (parse_result)
  );

  sfr_out_reg u_out (
    .clk         (clk),
    .rst         (rst),
    .load        (advance && emit),
    .load_result (parse_result),
    .take        (m_tready),
    .free        (out_free),
    .valid       (m_tvalid),
    .result      (out_result)
  );

  assign m_tdata = {out_result.second_param, out_result.first_param, out_result.event_code};
  assign m_tuser = out_result.checksum_bad;

endmodule

FILE: design/sfr_checker.sv
// Port-level checks for the serial frame receiver, bound to the top level.
module sfr_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [7:0]  s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic        m_tuser
);

  a_reset_clears: assert property (@(posedge clk)
    rst |=> (!m_tvalid && s_tready))
    else $error("result or stall present after reset");

  a_frame_from_trailer: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tdata == sfr_pkg::TRL_SECOND, 2))
    else $error("result not preceded by second trailer byte");

  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid)
    else $error("result withdrawn while stalled");

  a_data_holds: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> ($stable(m_tdata) && $stable(m_tuser)))
    else $error("result changed while stalled");

endmodule

bind serial_frame_receiver_unit sfr_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
